// File: hw/rtl/bdi_pkg.sv
package bdi_pkg;

  // Fraction bits of a barycentric weight; a weight never exceeds one,
  // so its quotient needs one integer bit on top.
  localparam int WFRAC = 24;
  localparam int QW    = WFRAC + 1;
  localparam int LANES = 3;

  // Control that rides next to the data of one pipeline stage
  typedef struct packed {
    logic valid;
    logic degenerate;
  } ctrl_t;

endpackage

// File: hw/rtl/bdi_if.sv
interface bdi_req_if #(
  parameter int COORD_WIDTH = 16,
  parameter int DEPTH_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_a_x;
  logic signed [COORD_WIDTH-1:0] vertex_a_y;
  logic signed [DEPTH_WIDTH-1:0] vertex_a_depth;
  logic signed [COORD_WIDTH-1:0] vertex_b_x;
  logic signed [COORD_WIDTH-1:0] vertex_b_y;
  logic signed [DEPTH_WIDTH-1:0] vertex_b_depth;
  logic signed [COORD_WIDTH-1:0] vertex_c_x;
  logic signed [COORD_WIDTH-1:0] vertex_c_y;
  logic signed [DEPTH_WIDTH-1:0] vertex_c_depth;
  logic signed [COORD_WIDTH-1:0] query_x;
  logic signed [COORD_WIDTH-1:0] query_y;

  modport source (
    output valid, vertex_a_x, vertex_a_y, vertex_a_depth, vertex_b_x, vertex_b_y,
           vertex_b_depth, vertex_c_x, vertex_c_y, vertex_c_depth, query_x, query_y,
    input  ready
  );
  modport sink (
    input  valid, vertex_a_x, vertex_a_y, vertex_a_depth, vertex_b_x, vertex_b_y,
           vertex_b_depth, vertex_c_x, vertex_c_y, vertex_c_depth, query_x, query_y,
    output ready
  );
endinterface

interface bdi_rsp_if #(
  parameter int DEPTH_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [DEPTH_WIDTH-1:0] interpolated_depth;
  logic                          degenerate;

  modport source (output valid, interpolated_depth, degenerate, input ready);
  modport sink   (input valid, interpolated_depth, degenerate, output ready);
endinterface

// File: hw/rtl/bdi_area.sv
module bdi_area #(
  parameter int CW = 16,
  parameter int DW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] xa,
  input  logic signed [CW-1:0] ya,
  input  logic signed [CW-1:0] xb,
  input  logic signed [CW-1:0] yb,
  input  logic signed [CW-1:0] xc,
  input  logic signed [CW-1:0] yc,
  input  logic signed [CW-1:0] qx,
  input  logic signed [CW-1:0] qy,
  input  logic signed [DW-1:0] depth_in [bdi_pkg::LANES],
  output bdi_pkg::ctrl_t       ctrl,
  output logic [2*(CW+1):0]    m [bdi_pkg::LANES],
  output logic [2*(CW+1)+2:0]  s,
  output logic signed [DW-1:0] depth_out [bdi_pkg::LANES]
);
  localparam int EW = CW + 1;
  localparam int PW = 2 * EW;
  localparam int AW = PW + 1;
  localparam int NW = AW + 2;
  localparam int MW = AW;
  localparam int SW = AW + 2;
  localparam int L  = bdi_pkg::LANES;

  logic v1, v2, v3, v4;
  logic signed [DW-1:0] dep1 [L];
  logic signed [DW-1:0] dep2 [L];
  logic signed [DW-1:0] dep3 [L];
  logic signed [DW-1:0] dep4 [L];

  // stage 1: edge differences
  logic signed [EW-1:0] dyb_c, dxc_b, dyc_a, dxa_c, dya_c, dqx, dqy;
  // stage 2: cross products
  logic signed [PW-1:0] pd1, pd2, pn1a, pn1b, pn2a, pn2b;
  // stage 3: doubled areas
  logic signed [AW-1:0] d3, n1_3, n2_3;
  // stage 4: sign-normalized areas
  logic signed [NW-1:0] dv4;
  logic signed [NW-1:0] nv4 [L];
  logic                 degen4;
  logic signed [NW-1:0] d_ext, n1_ext, n2_ext, n3_ext;
  logic [MW-1:0] mc [L];

  assign d_ext  = {{2{d3[AW-1]}}, d3};
  assign n1_ext = {{2{n1_3[AW-1]}}, n1_3};
  assign n2_ext = {{2{n2_3[AW-1]}}, n2_3};
  assign n3_ext = d_ext - n1_ext - n2_ext;

  always_comb begin
    for (int l = 0; l < L; l++) begin
      if (nv4[l][NW-1]) begin
        mc[l] = '0;
      end else if (nv4[l] > dv4) begin
        mc[l] = dv4[MW-1:0];
      end else begin
        mc[l] = nv4[l][MW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      ctrl <= '0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      ctrl.valid <= v4;
      ctrl.degenerate <= degen4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dyb_c <= $signed({yb[CW-1], yb}) - $signed({yc[CW-1], yc});
      dxc_b <= $signed({xc[CW-1], xc}) - $signed({xb[CW-1], xb});
      dyc_a <= $signed({yc[CW-1], yc}) - $signed({ya[CW-1], ya});
      dxa_c <= $signed({xa[CW-1], xa}) - $signed({xc[CW-1], xc});
      dya_c <= $signed({ya[CW-1], ya}) - $signed({yc[CW-1], yc});
      dqx   <= $signed({qx[CW-1], qx}) - $signed({xc[CW-1], xc});
      dqy   <= $signed({qy[CW-1], qy}) - $signed({yc[CW-1], yc});

      pd1  <= dyb_c * dxa_c;
      pd2  <= dxc_b * dya_c;
      pn1a <= dyb_c * dqx;
      pn1b <= dxc_b * dqy;
      pn2a <= dyc_a * dqx;
      pn2b <= dxa_c * dqy;

      d3   <= $signed({pd1[PW-1], pd1}) + $signed({pd2[PW-1], pd2});
      n1_3 <= $signed({pn1a[PW-1], pn1a}) + $signed({pn1b[PW-1], pn1b});
      n2_3 <= $signed({pn2a[PW-1], pn2a}) + $signed({pn2b[PW-1], pn2b});

      // flip a clockwise triangle so all areas compare against a positive total
      degen4 <= (d3 == '0);
      dv4    <= d3[AW-1] ? -d_ext  : d_ext;
      nv4[0] <= d3[AW-1] ? -n1_ext : n1_ext;
      nv4[1] <= d3[AW-1] ? -n2_ext : n2_ext;
      nv4[2] <= d3[AW-1] ? -n3_ext : n3_ext;

      for (int l = 0; l < L; l++) begin
        m[l] <= mc[l];
        dep1[l] <= depth_in[l];
        dep2[l] <= dep1[l];
        dep3[l] <= dep2[l];
        dep4[l] <= dep3[l];
        depth_out[l] <= dep4[l];
      end
      s <= SW'(mc[0]) + SW'(mc[1]) + SW'(mc[2]);
    end
  end

endmodule

// File: hw/rtl/bdi_divider.sv
module bdi_divider #(
  parameter int MW = 35,
  parameter int SW = 37,
  parameter int DW = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  bdi_pkg::ctrl_t              ctrl_in,
  input  logic [MW-1:0]               m [bdi_pkg::LANES],
  input  logic [SW-1:0]               s,
  input  logic signed [DW-1:0]        depth_in [bdi_pkg::LANES],
  output bdi_pkg::ctrl_t              ctrl_out,
  output logic [bdi_pkg::QW-1:0]      w [bdi_pkg::LANES],
  output logic signed [DW-1:0]        depth_out [bdi_pkg::LANES]
);
  localparam int QW   = bdi_pkg::QW;
  localparam int L    = bdi_pkg::LANES;
  localparam int NUMW = MW + bdi_pkg::WFRAC + 1;

  bdi_pkg::ctrl_t       ctl [QW+1];
  logic [SW-1:0]        dsr [QW+1];
  logic [SW-1:0]        rem [QW+1][L];
  logic [QW-1:0]        low [QW+1][L];
  logic [QW-1:0]        quo [QW+1][L];
  logic signed [DW-1:0] dep [QW+1][L];
  logic [NUMW-1:0]      num [L];

  // numerator m * 2^WFRAC + s/2; the quotient fits QW bits, so the
  // top bits start out as a remainder below s
  always_comb begin
    for (int l = 0; l < L; l++) begin
      num[l] = {1'b0, m[l], {bdi_pkg::WFRAC{1'b0}}} + NUMW'(s >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else if (en) begin
      ctl[0] <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsr[0] <= s;
      for (int l = 0; l < L; l++) begin
        rem[0][l] <= SW'(num[l][NUMW-1:QW]);
        low[0][l] <= num[l][QW-1:0];
        quo[0][l] <= '0;
        dep[0][l] <= depth_in[l];
      end
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [SW:0]   trial [L];
    logic [SW:0]   diff  [L];
    logic          ge    [L];

    always_comb begin
      for (int l = 0; l < L; l++) begin
        trial[l] = {rem[k][l], low[k][l][QW-1]};
        diff[l]  = trial[l] - {1'b0, dsr[k]};
        ge[l]    = (trial[l] >= {1'b0, dsr[k]});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[k+1] <= '0;
      end else if (en) begin
        ctl[k+1] <= ctl[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dsr[k+1] <= dsr[k];
        for (int l = 0; l < L; l++) begin
          rem[k+1][l] <= ge[l] ? diff[l][SW-1:0] : trial[l][SW-1:0];
          low[k+1][l] <= low[k][l] << 1;
          quo[k+1][l] <= {quo[k][l][QW-2:0], ge[l]};
          dep[k+1][l] <= dep[k][l];
        end
      end
    end
  end

  assign ctrl_out = ctl[QW];
  always_comb begin
    for (int l = 0; l < L; l++) begin
      w[l]         = quo[QW][l];
      depth_out[l] = dep[QW][l];
    end
  end

endmodule

// File: hw/rtl/bdi_blend.sv
module bdi_blend #(
  parameter int DW = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  bdi_pkg::ctrl_t         ctrl_in,
  input  logic [bdi_pkg::QW-1:0] w [bdi_pkg::LANES],
  input  logic signed [DW-1:0]   depth_in [bdi_pkg::LANES],
  output bdi_pkg::ctrl_t         ctrl_out,
  output logic signed [DW-1:0]   depth_out
);
  localparam int QW    = bdi_pkg::QW;
  localparam int WFRAC = bdi_pkg::WFRAC;
  localparam int L     = bdi_pkg::LANES;
  localparam int PRW   = QW + 1 + DW;
  localparam int ACW   = PRW + 2;
  localparam int QLW   = ACW - WFRAC;

  bdi_pkg::ctrl_t        c1, c2;
  logic signed [PRW-1:0] prod [L];
  logic signed [ACW-1:0] acc;
  logic signed [ACW-1:0] half;
  logic signed [ACW-1:0] t;
  logic signed [QLW-1:0] qv;
  logic signed [QLW-1:0] dmax_ext;
  logic signed [QLW-1:0] dmin_ext;
  logic signed [DW-1:0]  sat;

  assign half     = {{(ACW-WFRAC){1'b0}}, 1'b1, {(WFRAC-1){1'b0}}};
  assign t        = acc + half;
  // arithmetic shift gives floor, so rounding is half up for either sign
  assign qv       = t[ACW-1:WFRAC];
  assign dmax_ext = {{(QLW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  assign dmin_ext = {{(QLW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  always_comb begin
    if (qv > dmax_ext) begin
      sat = dmax_ext[DW-1:0];
    end else if (qv < dmin_ext) begin
      sat = dmin_ext[DW-1:0];
    end else begin
      sat = qv[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      ctrl_out <= '0;
    end else if (en) begin
      c1 <= ctrl_in;
      c2 <= c1;
      ctrl_out <= c2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < L; l++) begin
        prod[l] <= $signed({1'b0, w[l]}) * depth_in[l];
      end
      acc <= ACW'(prod[0]) + ACW'(prod[1]) + ACW'(prod[2]);
      depth_out <= c2.degenerate ? '0 : sat;
    end
  end

endmodule

// File: hw/rtl/barycentric_depth_interpolator_core.sv
// Barycentric depth interpolator: fully pipelined, one transaction per clock while the skid slot is empty.
// Pipeline: 5 area stages, 26 weight-divider stages (an input register, then one quotient
// bit per stage), 3 blend stages, output reg.
// Throughput: one transaction per cycle while the skid slot is empty, set by the bit-per-stage divider.
// Reset (rst, synchronous): clears all valid bits, including the output and skid flags.
module barycentric_depth_interpolator_core #(
  parameter int COORD_WIDTH = 16,
  parameter int DEPTH_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  bdi_req_if.sink   req,
  bdi_rsp_if.source rsp
);
  localparam int AW = 2 * (COORD_WIDTH + 1) + 1;
  localparam int MW = AW;
  localparam int SW = AW + 2;
  localparam int L  = bdi_pkg::LANES;

  // Pipeline advance: the whole pipe moves while the skid slot is empty,
  // so one more result can land behind a stalled output register.
  logic en;

  logic signed [DEPTH_WIDTH-1:0] dep_in [L];
  bdi_pkg::ctrl_t                area_ctrl;
  logic [MW-1:0]                 area_m [L];
  logic [SW-1:0]                 area_s;
  logic signed [DEPTH_WIDTH-1:0] area_dep [L];

  bdi_pkg::ctrl_t                div_ctrl;
  logic [bdi_pkg::QW-1:0]        div_w [L];
  logic signed [DEPTH_WIDTH-1:0] div_dep [L];

  bdi_pkg::ctrl_t                res_ctrl;
  logic signed [DEPTH_WIDTH-1:0] res_depth;

  // output register and skid slot
  logic                          ov, sv;
  logic signed [DEPTH_WIDTH-1:0] od_depth, sd_depth;
  logic                          od_degen, sd_degen;

  assign en        = !sv;
  assign req.ready = en;

  assign dep_in[0] = req.vertex_a_depth;
  assign dep_in[1] = req.vertex_b_depth;
  assign dep_in[2] = req.vertex_c_depth;

  // Signed areas, sign normalization, clamping and weight sum
  bdi_area #(.CW(COORD_WIDTH), .DW(DEPTH_WIDTH)) u_area (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (req.valid),
    .xa       (req.vertex_a_x),
    .ya       (req.vertex_a_y),
    .xb       (req.vertex_b_x),
    .yb       (req.vertex_b_y),
    .xc       (req.vertex_c_x),
    .yc       (req.vertex_c_y),
    .qx       (req.query_x),
    .qy       (req.query_y),
    .depth_in (dep_in),
    .ctrl     (area_ctrl),
    .m        (area_m),
    .s        (area_s),
    .depth_out(area_dep)
  );

  // Rounded weights m/s, three lanes sharing one divisor
  bdi_divider #(.MW(MW), .SW(SW), .DW(DEPTH_WIDTH)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctrl_in  (area_ctrl),
    .m        (area_m),
    .s        (area_s),
    .depth_in (area_dep),
    .ctrl_out (div_ctrl),
    .w        (div_w),
    .depth_out(div_dep)
  );

  // Weighted depth sum, rounding and saturation
  bdi_blend #(.DW(DEPTH_WIDTH)) u_blend (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctrl_in  (div_ctrl),
    .w        (div_w),
    .depth_in (div_dep),
    .ctrl_out (res_ctrl),
    .depth_out(res_depth)
  );

  // Output stage: refill from the skid slot first, else take the pipe head.
  // When the output holds a stalled transaction, park a new result in the skid.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (!ov || rsp.ready) begin
      if (sv) begin
        ov <= 1'b1;
        sv <= 1'b0;
      end else begin
        ov <= res_ctrl.valid;
      end
    end else if (res_ctrl.valid && !sv) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || rsp.ready) begin
      if (sv) begin
        od_depth <= sd_depth;
        od_degen <= sd_degen;
      end else begin
        od_depth <= res_depth;
        od_degen <= res_ctrl.degenerate;
      end
    end else if (res_ctrl.valid && !sv) begin
      sd_depth <= res_depth;
      sd_degen <= res_ctrl.degenerate;
    end
  end

  assign rsp.valid              = ov;
  assign rsp.interpolated_depth = od_depth;
  assign rsp.degenerate         = od_degen;

  // The skid slot only ever holds a transaction behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst) sv |-> ov)
    else $error("skid slot valid with empty output register");

  // The skid slot fills only when the output was stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(sv) |-> $past(ov && !rsp.ready))
    else $error("skid slot filled without an output stall");

  // A degenerate triangle always reports zero depth
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (ov && od_degen) |-> (od_depth == '0))
    else $error("degenerate response with nonzero depth");

endmodule
